// File: rtl/abdf_pkg.sv
package abdf_pkg;

    localparam int FRAC_BITS      = 15;
    localparam int VAL_W          = 16;
    localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;
    localparam int MAX_RADIUS_DEF = 30;
    localparam int STEP_MAX       = 8;
    localparam int STEP_W         = 4;
    localparam int RADIUS_W       = 5;
    localparam int FILL_W         = 7;
    localparam logic [FILL_W-1:0] FILL_MAX = '1;
    localparam int OP_W           = 2;
    localparam int TIDX_IN_W      = 6;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 16;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD_GAUSS = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_DIST  = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE     = 2'd2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CENTRE,
        ST_TAP,
        ST_DRAIN,
        ST_DIV_GO,
        ST_DIV,
        ST_MUL,
        ST_FIN,
        ST_EMIT
    } abdf_state_t;

    typedef struct packed {
        logic table_wr;
        logic sample_wr;
        logic setup;
        logic centre_rd;
        logic tap_rd;
        logic div_start;
        logic mul_en;
        logic fin_en;
        logic emit;
        logic next_pix;
        logic line_end;
    } abdf_cmd_t;

    typedef struct packed {
        logic has_pixel;
        logic taps_done;
        logic div_done;
        logic out_free;
        logic more_pix;
    } abdf_stat_t;

endpackage

// File: rtl/abdf_ram.sv
module abdf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 61
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read with a registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/abdf_div.sv
module abdf_div import abdf_pkg::*; #(
    parameter int AW = 38,
    parameter int SW = 22
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    dividend,
    input  logic [SW-1:0]    divisor,
    output logic             done,
    output logic [VAL_W-1:0] quotient
);

    localparam int QB  = FRAC_BITS + 1;
    localparam int CNW = $clog2(QB + 1);

    logic [SW-1:0]  rem_reg, rem_next;
    logic [QB-1:0]  dvd_reg, dvd_next;
    logic [QB-1:0]  q_reg, q_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic           sat_reg, sat_next;
    logic [SW-1:0]  hi;
    logic [SW:0]    trial;
    logic           fits;

    assign hi    = SW'(dividend >> QB);
    assign trial = {rem_reg, dvd_reg[QB-1]};
    assign fits  = trial >= {1'b0, divisor};

    // One quotient bit per cycle, restoring form
    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        if (start)
        begin
            if (hi >= divisor)
            begin
                sat_next  = 1'b1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                sat_next  = 1'b0;
                rem_next  = hi;
                dvd_next  = dividend[QB-1:0];
                q_next    = '0;
                cnt_next  = CNW'(QB);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? SW'(trial - {1'b0, divisor}) : trial[SW-1:0];
            q_next   = {q_reg[QB-2:0], fits};
            dvd_next = {dvd_reg[QB-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    // Saturate to 1.0
    assign done     = done_reg;
    assign quotient = (sat_reg || (q_reg > QB'(ONE))) ? ONE : VAL_W'(q_reg);

endmodule

// File: rtl/abdf_dpath.sv
module abdf_dpath import abdf_pkg::*; #(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  abdf_cmd_t             cmd,
    output abdf_stat_t            stat,
    output logic                  m_tvalid,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    input  logic                  m_tready
);

    localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int ADDR_W    = $clog2(WIN_DEPTH);
    localparam int RW        = $clog2(MAX_RADIUS + 1);
    localparam int TW        = $clog2(2 * MAX_RADIUS + STEP_MAX + 1);
    localparam int XW        = (TW + 1 > FILL_W) ? TW + 1 : FILL_W;
    localparam int PW        = 2 * VAL_W;
    localparam int AW        = PW + ADDR_W;
    localparam int SW        = VAL_W + ADDR_W;

    logic [OP_W-1:0]      op;
    logic [TIDX_IN_W-1:0] tab;
    logic [VAL_W-1:0]     wval;
    logic [VAL_W-1:0]     sval;

    logic [RADIUS_W-1:0] radius_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                invert_reg;
    logic [RW-1:0]       r_eff;
    logic [STEP_W-1:0]   step_eff;

    logic [ADDR_W-1:0]  wptr_reg, wptr_next;
    logic [FILL_W-1:0]  fill_reg;
    logic               line_last_reg;
    logic [RW-1:0]      e_reg;
    logic [TW-1:0]      er_reg;
    logic [TW-1:0]      tidx_reg;
    logic               tap_vld_reg;
    logic               centre_vld_reg;

    logic               tab_ok;
    logic [ADDR_W-1:0]  tab_addr;
    logic [VAL_W-1:0]   win_wdata;
    logic [TW-1:0]      widx;
    logic [ADDR_W:0]    back;
    logic [ADDR_W-1:0]  win_raddr;
    logic [VAL_W-1:0]   win_rdata, gauss_rdata, dist_rdata;
    logic [XW-1:0]      a_x, f_x;
    logic [TW-1:0]      tap_start;
    logic [FILL_W-1:0]  fill_m1;

    logic [VAL_W-1:0]   v_map, m_cl, sv_t;
    logic [PW-1:0]      prod_vg, prod_vm;
    logic [AW-1:0]      acc_reg;
    logic [SW-1:0]      wsum_reg;
    logic [VAL_W-1:0]   vmax_reg, dmax_reg, centre_raw_reg;
    logic [VAL_W-1:0]   blur;
    logic               div_done;
    logic [PW-1:0]      p1_reg, p2_reg;
    logic [PW:0]        psum;
    logic [PW-FRAC_BITS:0] fin;
    logic [VAL_W-1:0]   fin_cl, fin_map;
    logic [VAL_W-1:0]   res_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic               m_tlast_reg;

    // Unpack the input word
    assign op   = s_tdata[1:0];
    assign tab  = s_tdata[7:2];
    assign wval = s_tdata[23:8];
    assign sval = s_tdata[39:24];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            step_reg   <= STEP_W'(1);
            invert_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_STEP:   step_reg   <= cfg_data[STEP_W-1:0];
                REG_INVERT: invert_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Clamp radius and step
    always_comb
    begin
        if (8'(radius_reg) > 8'(MAX_RADIUS))
        begin
            r_eff = RW'(MAX_RADIUS);
        end
        else
        begin
            r_eff = RW'(radius_reg);
        end
        if (step_reg == '0)
        begin
            step_eff = STEP_W'(1);
        end
        else if (step_reg > STEP_W'(STEP_MAX))
        begin
            step_eff = STEP_W'(STEP_MAX);
        end
        else
        begin
            step_eff = step_reg;
        end
    end

    // Table and window writes
    assign tab_ok    = 8'(tab) < 8'(WIN_DEPTH);
    assign tab_addr  = ADDR_W'(tab);
    assign win_wdata = (sval > ONE) ? ONE : sval;
    assign wptr_next = (wptr_reg == ADDR_W'(WIN_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;

    // Window read address: newest entry minus distance, wrapped
    assign widx = cmd.centre_rd ? TW'(e_reg) : er_reg - tidx_reg;
    assign back = {1'b0, wptr_reg} - (ADDR_W + 1)'(widx);
    assign win_raddr = back[ADDR_W] ? ADDR_W'(back + (ADDR_W + 1)'(WIN_DEPTH))
                                    : back[ADDR_W-1:0];

    abdf_ram #(.WIDTH(VAL_W), .DEPTH(WIN_DEPTH)) u_win_ram (
        .clk   (clk),
        .we    (cmd.sample_wr),
        .waddr (wptr_next),
        .wdata (win_wdata),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    abdf_ram #(.WIDTH(VAL_W), .DEPTH(WIN_DEPTH)) u_gauss_ram (
        .clk   (clk),
        .we    (cmd.table_wr && (op == OP_LOAD_GAUSS) && tab_ok),
        .waddr (tab_addr),
        .wdata (wval),
        .raddr (tidx_reg[ADDR_W-1:0]),
        .rdata (gauss_rdata)
    );

    abdf_ram #(.WIDTH(VAL_W), .DEPTH(WIN_DEPTH)) u_dist_ram (
        .clk   (clk),
        .we    (cmd.table_wr && (op == OP_LOAD_DIST) && tab_ok),
        .waddr (tab_addr),
        .wdata (wval),
        .raddr (tidx_reg[ADDR_W-1:0]),
        .rdata (dist_rdata)
    );

    // First tap clipped at the start of the line
    assign a_x       = XW'(e_reg) + XW'(r_eff) + XW'(1);
    assign f_x       = XW'(fill_reg);
    assign tap_start = (a_x > f_x) ? TW'(a_x - f_x) : '0;
    assign fill_m1   = fill_reg - 1'b1;

    // Line and tap control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg       <= '0;
            fill_reg       <= '0;
            line_last_reg  <= 1'b0;
            e_reg          <= '0;
            er_reg         <= '0;
            tidx_reg       <= '0;
            tap_vld_reg    <= 1'b0;
            centre_vld_reg <= 1'b0;
        end
        else
        begin
            tap_vld_reg    <= cmd.tap_rd;
            centre_vld_reg <= cmd.centre_rd;
            if (cmd.sample_wr)
            begin
                wptr_reg      <= wptr_next;
                line_last_reg <= s_tlast;
                if (fill_reg != FILL_MAX)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            // Restart the count only after the final word of a line
            if (cmd.line_end && line_last_reg)
            begin
                fill_reg <= '0;
            end
            if (cmd.setup)
            begin
                if (line_last_reg && (fill_m1 < FILL_W'(r_eff)))
                begin
                    e_reg <= RW'(fill_m1);
                end
                else
                begin
                    e_reg <= r_eff;
                end
            end
            if (cmd.next_pix)
            begin
                e_reg <= e_reg - 1'b1;
            end
            if (cmd.centre_rd)
            begin
                er_reg   <= TW'(e_reg) + TW'(r_eff);
                tidx_reg <= tap_start;
            end
            if (cmd.tap_rd)
            begin
                tidx_reg <= tidx_reg + TW'(step_eff);
            end
        end
    end

    // Tap arithmetic: weighted sum and scaled dilate
    assign v_map   = invert_reg ? ONE - win_rdata : win_rdata;
    assign m_cl    = (dist_rdata > ONE) ? ONE : dist_rdata;
    assign prod_vg = v_map * gauss_rdata;
    assign prod_vm = v_map * m_cl;
    assign sv_t    = VAL_W'(prod_vm >> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (cmd.centre_rd)
        begin
            acc_reg  <= '0;
            wsum_reg <= '0;
        end
        if (centre_vld_reg)
        begin
            centre_raw_reg <= win_rdata;
            vmax_reg       <= v_map;
            dmax_reg       <= ONE;
        end
        if (tap_vld_reg)
        begin
            acc_reg  <= acc_reg + AW'(prod_vg);
            wsum_reg <= wsum_reg + SW'(gauss_rdata);
            if ((v_map > vmax_reg) && (sv_t > vmax_reg))
            begin
                vmax_reg <= sv_t;
                dmax_reg <= m_cl;
            end
        end
    end

    abdf_div #(.AW(AW), .SW(SW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (wsum_reg),
        .done     (div_done),
        .quotient (blur)
    );

    // Blend max and blur
    assign psum    = (PW + 1)'(p1_reg) + (PW + 1)'(p2_reg);
    assign fin     = psum[PW:FRAC_BITS];
    assign fin_cl  = (fin > (PW - FRAC_BITS + 1)'(ONE)) ? ONE : VAL_W'(fin);
    assign fin_map = invert_reg ? ONE - fin_cl : fin_cl;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            p1_reg <= vmax_reg * dmax_reg;
            p2_reg <= blur * (ONE - dmax_reg);
        end
        if (cmd.fin_en)
        begin
            res_reg <= (wsum_reg == '0) ? centre_raw_reg : fin_map;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_tdata_reg <= M_TDATA_W'(res_reg);
            m_tlast_reg <= line_last_reg && (e_reg == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Status to the controller
    assign stat.has_pixel = line_last_reg || (fill_reg >= FILL_W'(r_eff) + 1'b1);
    assign stat.taps_done = tidx_reg > er_reg;
    assign stat.div_done  = div_done;
    assign stat.out_free  = !m_tvalid_reg || m_tready;
    assign stat.more_pix  = line_last_reg && (e_reg != '0);

    a_centre_has_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.centre_rd |-> fill_reg != '0)
        else $error("pixel started with empty line");

    a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tap_rd |-> tidx_reg <= er_reg)
        else $error("tap index beyond window end");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result overwrites pending word");

    a_vmax_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tap_vld_reg |=> vmax_reg <= ONE)
        else $error("dilate maximum above one");

endmodule

// File: rtl/abdf_ctrl.sv
module abdf_ctrl import abdf_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic [OP_W-1:0] op,
    input  abdf_stat_t      stat,
    output logic            s_tready,
    output abdf_cmd_t       cmd
);

    abdf_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one item: a table write, or a window write then one pass per pixel
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (op inside {OP_LOAD_GAUSS, OP_LOAD_DIST})
                    begin
                        cmd.table_wr = 1'b1;
                    end
                    else if (op == OP_SAMPLE)
                    begin
                        cmd.sample_wr = 1'b1;
                        state_next    = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = stat.has_pixel ? ST_CENTRE : ST_IDLE;
            end
            ST_CENTRE:
            begin
                cmd.centre_rd = 1'b1;
                state_next    = ST_TAP;
            end
            ST_TAP:
            begin
                if (stat.taps_done)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.tap_rd = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.fin_en = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.more_pix)
                    begin
                        cmd.next_pix = 1'b1;
                        state_next   = ST_CENTRE;
                    end
                    else
                    begin
                        cmd.line_end = stat.more_pix ? 1'b0 : 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/alpha_blur_dilate_feather_line_unit.sv
// A load word is written to its table and the unit stays ready; a sample word
// holds s_tready low until its result words are emitted, each taking a walk over
// the window taps used (up to 2R+1). Throughput is set by the tap walk over the
// window and table memories (one tap a cycle) and the bit-serial divider; a line end
// flushes up to R+1 words. Reset (asynchronous, active low) clears configuration,
// line count and the output valid; weight tables hold garbage until loaded.
module alpha_blur_dilate_feather_line_unit import abdf_pkg::*; #(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // operation[1:0], table_index[7:2], weight_value[23:8], sample_value[39:24]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // filtered_value[15:0]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast
);

    abdf_cmd_t  cmd;
    abdf_stat_t stat;

    abdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .op       (s_tdata[OP_W-1:0]),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    abdf_dpath #(.MAX_RADIUS(MAX_RADIUS)) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tready (m_tready)
    );

endmodule
